[rtl/core/ntl_pkg.sv]
// ----------------------------------------------------------------------------
// ntl_pkg
// Shared types and constants for the nibble trie lookup and insert block.
// ----------------------------------------------------------------------------
package ntl_pkg;

	localparam int KIND_W  = 2;
	localparam int NODE_W  = 12;
	localparam int CP_W    = 32;
	localparam int TAG_W   = 16;
	localparam int NIB_W   = 4;
	localparam int FANOUT  = 16;

	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_WALK,
		ST_FIN_RD,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              from_root;
		logic [NODE_W-1:0] start_node;
		logic [CP_W-1:0]   codepoint;
		logic [TAG_W-1:0]  tag;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              found;
		logic [TAG_W-1:0]  node_tag;
		logic              pool_full;
	} res_t;

endpackage

[rtl/core/ntl_walker.sv]
// ----------------------------------------------------------------------------
// ntl_walker
// Node memory and walk sequencer: one row per node holds its 16 child links
// and its tag; one nibble level is resolved per cycle.
// ----------------------------------------------------------------------------
module ntl_walker #(
	parameter int NODE_COUNT     = 4096,
	parameter int CODEPOINT_BITS = 32,
	parameter int TAG_BITS       = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ntl_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output ntl_pkg::res_t res
);
	import ntl_pkg::*;

	localparam int NB     = $clog2(NODE_COUNT);
	localparam int LEVELS = CODEPOINT_BITS / NIB_W;
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int LINK_W = FANOUT * NB;
	localparam int ROW_W  = LINK_W + TAG_BITS;

	logic [ROW_W-1:0] node_mem_q [NODE_COUNT];
	logic [ROW_W-1:0] rd_q;

	state_t                    state_q, state_d;
	logic [KIND_W-1:0]         kind_q, kind_d;
	logic                      from_root_q, from_root_d;
	logic [NODE_W-1:0]         start_q, start_d;
	logic [CODEPOINT_BITS-1:0] cp_sh_q, cp_sh_d;
	logic [TAG_BITS-1:0]       tag_q, tag_d;
	logic [LVL_W-1:0]          lvl_q, lvl_d;
	logic [NB-1:0]             cur_q, cur_d;
	logic [ROW_W-1:0]          row_q, row_d;
	logic                      use_mem_q, use_mem_d;
	logic                      dirty_q, dirty_d;
	logic [NB:0]               nodes_used_q, nodes_used_d;
	logic                      root_q, root_d;
	res_t                      res_q, res_d;

	logic             we, re;
	logic [NB-1:0]    waddr, raddr;
	logic [ROW_W-1:0] wdata;

	logic [ROW_W-1:0]    cur_row, row_upd, row_tagged;
	logic [NIB_W-1:0]    nib;
	logic [NB-1:0]       link;
	logic [TAG_BITS-1:0] row_tag, rd_tag;
	logic                pool_out, last_lvl, tag_set;

	assign cur_row  = use_mem_q ? rd_q : row_q;
	assign nib      = cp_sh_q[CODEPOINT_BITS-1 -: NIB_W];
	assign link     = cur_row[nib * NB +: NB];
	assign row_tag  = cur_row[ROW_W-1 -: TAG_BITS];
	assign rd_tag   = rd_q[ROW_W-1 -: TAG_BITS];
	assign pool_out = nodes_used_q >= (NB+1)'(NODE_COUNT);
	assign last_lvl = lvl_q == '0;
	assign tag_set  = (kind_q == KIND_APPEND) && (tag_q != '0);

	always_comb begin
		row_upd = cur_row;
		row_upd[nib * NB +: NB] = nodes_used_q[NB-1:0];
		row_tagged = rd_q;
		row_tagged[ROW_W-1 -: TAG_BITS] = tag_q;
	end

	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		from_root_d  = from_root_q;
		start_d      = start_q;
		cp_sh_d      = cp_sh_q;
		tag_d        = tag_q;
		lvl_d        = lvl_q;
		cur_d        = cur_q;
		row_d        = row_q;
		use_mem_d    = use_mem_q;
		dirty_d      = dirty_q;
		nodes_used_d = nodes_used_q;
		root_d       = root_q;
		res_d        = res_q;
		we           = 1'b0;
		waddr        = cur_q;
		wdata        = row_q;
		re           = 1'b0;
		raddr        = cur_q;
		req_ready    = 1'b0;
		res_valid    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					kind_d      = req.kind;
					from_root_d = req.from_root;
					start_d     = req.start_node;
					cp_sh_d     = req.codepoint[CODEPOINT_BITS-1:0];
					tag_d       = TAG_BITS'(req.tag);
					lvl_d       = LVL_W'(LEVELS - 1);
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				res_d   = '0;
				state_d = ST_FINISH;
				case (kind_q) inside
					KIND_APPEND, KIND_FIND: begin
						if (from_root_q) begin
							if (!root_q) begin
								if (kind_q == KIND_FIND) begin
									state_d = ST_FINISH;
								end else if (pool_out) begin
									res_d.pool_full = 1'b1;
								end else begin
									nodes_used_d = nodes_used_q + 1'b1;
									root_d       = 1'b1;
									cur_d        = '0;
									row_d        = '0;
									dirty_d      = 1'b1;
									use_mem_d    = 1'b0;
									state_d      = ST_WALK;
								end
							end else begin
								re        = 1'b1;
								raddr     = '0;
								cur_d     = '0;
								use_mem_d = 1'b1;
								dirty_d   = 1'b0;
								state_d   = ST_WALK;
							end
						end else if (32'(start_q) < 32'(nodes_used_q)) begin
							re        = 1'b1;
							raddr     = NB'(start_q);
							cur_d     = NB'(start_q);
							use_mem_d = 1'b1;
							dirty_d   = 1'b0;
							state_d   = ST_WALK;
						end
					end
					KIND_CLEAR: begin
						nodes_used_d = '0;
						root_d       = 1'b0;
					end
					default: begin
						res_d = '0;
					end
				endcase
			end
			ST_WALK: begin
				if (link != '0) begin
					cur_d     = link;
					re        = 1'b1;
					raddr     = link;
					use_mem_d = 1'b1;
					dirty_d   = 1'b0;
					if (last_lvl) begin
						state_d = ST_FIN_RD;
					end else begin
						lvl_d   = lvl_q - LVL_W'(1);
						cp_sh_d = cp_sh_q << NIB_W;
					end
				end else if (kind_q == KIND_FIND) begin
					res_d   = '0;
					state_d = ST_FINISH;
				end else if (pool_out) begin
					// keep a node made earlier in this walk
					we              = dirty_q;
					waddr           = cur_q;
					wdata           = cur_row;
					res_d.node      = NODE_W'(cur_q);
					res_d.found     = 1'b0;
					res_d.node_tag  = TAG_W'(row_tag);
					res_d.pool_full = 1'b1;
					state_d         = ST_FINISH;
				end else begin
					we           = 1'b1;
					waddr        = cur_q;
					wdata        = row_upd;
					nodes_used_d = nodes_used_q + 1'b1;
					cur_d        = nodes_used_q[NB-1:0];
					row_d        = '0;
					if (last_lvl && tag_q != '0) begin
						row_d[ROW_W-1 -: TAG_BITS] = tag_q;
					end
					dirty_d   = 1'b1;
					use_mem_d = 1'b0;
					if (last_lvl) begin
						state_d = ST_FLUSH;
					end else begin
						lvl_d   = lvl_q - LVL_W'(1);
						cp_sh_d = cp_sh_q << NIB_W;
					end
				end
			end
			ST_FLUSH: begin
				we              = 1'b1;
				waddr           = cur_q;
				wdata           = row_q;
				res_d.node      = NODE_W'(cur_q);
				res_d.found     = 1'b1;
				res_d.node_tag  = TAG_W'(row_q[ROW_W-1 -: TAG_BITS]);
				res_d.pool_full = 1'b0;
				state_d         = ST_FINISH;
			end
			ST_FIN_RD: begin
				we              = tag_set;
				waddr           = cur_q;
				wdata           = row_tagged;
				res_d.node      = NODE_W'(cur_q);
				res_d.found     = 1'b1;
				res_d.node_tag  = tag_set ? TAG_W'(tag_q) : TAG_W'(rd_tag);
				res_d.pool_full = 1'b0;
				state_d         = ST_FINISH;
			end
			ST_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res = res_q;

	// node memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			node_mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= node_mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nodes_used_q <= '0;
			root_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			nodes_used_q <= nodes_used_d;
			root_q       <= root_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q      <= kind_d;
		from_root_q <= from_root_d;
		start_q     <= start_d;
		cp_sh_q     <= cp_sh_d;
		tag_q       <= tag_d;
		lvl_q       <= lvl_d;
		cur_q       <= cur_d;
		row_q       <= row_d;
		use_mem_q   <= use_mem_d;
		dirty_q     <= dirty_d;
		res_q       <= res_d;
	end

endmodule

[rtl/core/nibble_trie_lookup_insert.sv]
// sequence: dispatch, one node memory read per nibble level, then final tag access;
// clear and rejected items go from dispatch straight to the result; a new item is
// taken only after the walker has handed its result to the output register
// reset: empty trie, no root, no memory clearing pass
// ----------------------------------------------------------------------------
// nibble_trie_lookup_insert
// Radix-16 trie over a fixed node pool: append, find and clear of codepoints,
// with an output register so the walker can work on the next item while a result waits.
// ----------------------------------------------------------------------------
module nibble_trie_lookup_insert #(
	parameter int NODE_COUNT     = 4096,
	parameter int CODEPOINT_BITS = 32,
	parameter int TAG_BITS       = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ntl_pkg::KIND_W-1:0] kind,
	input  logic                      from_root,
	input  logic [ntl_pkg::NODE_W-1:0] start_node,
	input  logic [ntl_pkg::CP_W-1:0]   codepoint,
	input  logic [ntl_pkg::TAG_W-1:0]  tag,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ntl_pkg::NODE_W-1:0] node,
	output logic                      found,
	output logic [ntl_pkg::TAG_W-1:0]  node_tag,
	output logic                      pool_full
);
	import ntl_pkg::*;

	req_t req;
	res_t res;
	res_t out_q;
	logic res_valid, res_ready;
	logic out_valid_q;

	assign req.kind       = kind;
	assign req.from_root  = from_root;
	assign req.start_node = start_node;
	assign req.codepoint  = codepoint;
	assign req.tag        = tag;

	ntl_walker #(
		.NODE_COUNT     (NODE_COUNT),
		.CODEPOINT_BITS (CODEPOINT_BITS),
		.TAG_BITS       (TAG_BITS)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register frees the walker once the result moves in
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign node      = out_q.node;
	assign found     = out_q.found;
	assign node_tag  = out_q.node_tag;
	assign pool_full = out_q.pool_full;

endmodule

[tb/tb_nibble_trie_lookup_insert.sv]
// ----------------------------------------------------------------------------
// tb_nibble_trie_lookup_insert
// Self-checking bench for the radix-16 trie block. A queue-fed driver offers
// directed items, a pool-exhausting append run and a random mix of appends,
// finds, clears and spare kinds. A monitor keeps a shadow trie, predicts each result
// at the input transfer and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb_nibble_trie_lookup_insert;

	import ntl_pkg::*;

	localparam int NODE_COUNT = 4096;
	localparam int LEVELS = CP_W / NIB_W;
	localparam int RUN_ITEMS = 1300;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KIND_W-1:0] kind = '0;
	logic from_root = 1'b0;
	logic [NODE_W-1:0] start_node = '0;
	logic [CP_W-1:0] codepoint = '0;
	logic [TAG_W-1:0] tag = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [NODE_W-1:0] node;
	logic found;
	logic [TAG_W-1:0] node_tag;
	logic pool_full;

	nibble_trie_lookup_insert dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.from_root(from_root),
		.start_node(start_node),
		.codepoint(codepoint),
		.tag(tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.node(node),
		.found(found),
		.node_tag(node_tag),
		.pool_full(pool_full)
	);

	// shadow trie
	logic [NODE_W-1:0] link_mem [0:NODE_COUNT*FANOUT-1];
	logic [TAG_W-1:0] tag_mem [0:NODE_COUNT-1];
	int nodes_alloc = 0;
	bit root_made = 1'b0;

	req_t pending_q[$];
	res_t result_q[$];
	logic [CP_W-1:0] known_cp[$];
	int n_total = 0;
	int n_in = 0;
	int errors = 0;
	int cycles = 0;
	bit in_took = 1'b0;
	bit out_took = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;
	bit hold_off = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic take_node(output bit ok, output logic [NODE_W-1:0] idx);
		int s;
		ok = (nodes_alloc < NODE_COUNT);
		idx = '0;
		if (ok) begin
			idx = NODE_W'(nodes_alloc);
			for (s = 0; s < FANOUT; s++)
				link_mem[{idx, s[NIB_W-1:0]}] = '0;
			tag_mem[idx] = '0;
			nodes_alloc++;
		end
	endtask

	task automatic trie_apply(input req_t r, output res_t res);
		logic [NODE_W-1:0] cur;
		logic [NODE_W-1:0] nxt;
		logic [NIB_W-1:0] nib;
		logic [NODE_W+NIB_W-1:0] slot;
		bit ok;
		bit done;
		int lvl;
		res = '0;
		done = 1'b0;
		cur = '0;
		if (r.kind == KIND_CLEAR) begin
			nodes_alloc = 0;
			root_made = 1'b0;
			done = 1'b1;
		end else if (r.kind == KIND_SPARE) begin
			done = 1'b1;
		end else if (r.from_root) begin
			if (!root_made) begin
				if (r.kind == KIND_FIND) begin
					done = 1'b1;
				end else begin
					take_node(ok, nxt);
					if (!ok) begin
						res.pool_full = 1'b1;
						done = 1'b1;
					end else begin
						root_made = 1'b1;
					end
				end
			end
		end else if (r.start_node >= nodes_alloc) begin
			done = 1'b1;
		end else begin
			cur = r.start_node;
		end
		for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
			if (!done) begin
				nib = r.codepoint[lvl*NIB_W +: NIB_W];
				slot = {cur, nib};
				nxt = link_mem[slot];
				if (nxt == '0) begin
					if (r.kind == KIND_FIND) begin
						done = 1'b1;
					end else begin
						take_node(ok, nxt);
						if (!ok) begin
							res.node = cur;
							res.node_tag = tag_mem[cur];
							res.pool_full = 1'b1;
							done = 1'b1;
						end else begin
							link_mem[slot] = nxt;
						end
					end
				end
				if (!done) begin
					if (r.kind == KIND_APPEND && lvl == 0 && r.tag != '0)
						tag_mem[nxt] = r.tag;
					cur = nxt;
				end
			end
		end
		if (!done) begin
			res.node = cur;
			res.found = 1'b1;
			res.node_tag = tag_mem[cur];
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want_v, got_v);
			errors++;
		end
	endtask

	function automatic int idle_len(bit steady);
		int p;
		if (steady)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_item(input logic [KIND_W-1:0] k, input logic fr,
			input logic [NODE_W-1:0] sn, input logic [CP_W-1:0] cp,
			input logic [TAG_W-1:0] tg);
		req_t r;
		r.kind = k;
		r.from_root = fr;
		r.start_node = sn;
		r.codepoint = cp;
		r.tag = tg;
		pending_q.push_back(r);
		n_total++;
		if (k == KIND_APPEND) begin
			known_cp.push_back(cp);
			if (known_cp.size() > 128)
				void'(known_cp.pop_front());
		end
	endtask

	function automatic logic [CP_W-1:0] some_known_cp();
		if (known_cp.size() == 0)
			return $urandom;
		return known_cp[$urandom_range(0, known_cp.size() - 1)];
	endfunction

	function automatic logic [NODE_W-1:0] some_start();
		if (nodes_alloc == 0 || $urandom_range(0, 3) == 0)
			return NODE_W'($urandom_range(0, NODE_COUNT - 1));
		return NODE_W'($urandom_range(0, nodes_alloc - 1));
	endfunction

	task automatic push_random();
		int p;
		bit fr;
		logic [CP_W-1:0] cp;
		logic [TAG_W-1:0] tg;
		p = $urandom_range(0, 99);
		fr = ($urandom_range(0, 4) != 0);
		case ($urandom_range(0, 9)) inside
			[0:2]: cp = $urandom;
			[3:5]: cp = some_known_cp() ^ CP_W'($urandom_range(0, 255));
			default: cp = some_known_cp();
		endcase
		tg = ($urandom_range(0, 3) == 0) ? '0 : TAG_W'($urandom_range(1, 65535));
		if (p < 3)
			push_item(KIND_CLEAR, 1'($urandom), NODE_W'($urandom), $urandom,
				TAG_W'($urandom));
		else if (p < 6)
			push_item(KIND_SPARE, 1'($urandom), NODE_W'($urandom), $urandom,
				TAG_W'($urandom));
		else if (p < 50)
			push_item(KIND_APPEND, fr, fr ? NODE_W'($urandom) : some_start(), cp, tg);
		else
			push_item(KIND_FIND, fr, fr ? NODE_W'($urandom) : some_start(), cp,
				TAG_W'($urandom));
	endtask

	// sender
	always @(negedge clk) begin
		req_t r;
		if (arst_n) begin
			if (in_valid && !in_took) begin
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_q.size() > 0) begin
				r = pending_q.pop_front();
				{kind, from_root, start_node, codepoint, tag} <= r;
				in_valid <= 1'b1;
				send_gap <= idle_len(send_steady);
				if ($urandom_range(0, 49) == 0)
					send_steady <= !send_steady;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		int g;
		if (!arst_n || hold_off) begin
			out_ready <= 1'b0;
		end else if (out_took) begin
			g = idle_len(recv_steady);
			stall_left <= g;
			out_ready <= (g == 0);
			if ($urandom_range(0, 39) == 0)
				recv_steady <= !recv_steady;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else if (!recv_steady && $urandom_range(0, 15) == 0) begin
			stall_left <= idle_len(1'b0);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor and prediction
	always @(posedge clk) begin
		res_t got;
		res_t want;
		req_t acc;
		in_took <= arst_n && in_valid && in_ready;
		out_took <= arst_n && out_valid && out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {node, found, node_tag, pool_full};
				if (result_q.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, got %0h %0b %0h %0b",
						$time, got.node, got.found, got.node_tag, got.pool_full);
					errors++;
				end else begin
					want = result_q.pop_front();
					check_field("node", 32'(want.node), 32'(got.node));
					check_field("found", 32'(want.found), 32'(got.found));
					check_field("node_tag", 32'(want.node_tag), 32'(got.node_tag));
					check_field("pool_full", 32'(want.pool_full), 32'(got.pool_full));
				end
			end
			if (in_valid && in_ready) begin
				acc = {kind, from_root, start_node, codepoint, tag};
				trie_apply(acc, want);
				result_q.push_back(want);
				n_in++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		while (n_in < 300)
			@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int k;
		// directed: missing root, unallocated start, extremes, tag keep, miss, clear
		push_item(KIND_FIND, 1'b1, 12'h000, 32'h12345678, 16'h0000);
		push_item(KIND_APPEND, 1'b0, 12'h005, 32'hDEADBEEF, 16'h1234);
		push_item(KIND_FIND, 1'b0, 12'hFFF, 32'h00000000, 16'h0000);
		push_item(KIND_APPEND, 1'b1, 12'h000, 32'h00000000, 16'hFFFF);
		push_item(KIND_FIND, 1'b1, 12'h000, 32'h00000000, 16'h0000);
		push_item(KIND_APPEND, 1'b1, 12'hFFF, 32'hFFFFFFFF, 16'h0001);
		push_item(KIND_APPEND, 1'b1, 12'h000, 32'hFFFFFFFF, 16'h0000);
		push_item(KIND_FIND, 1'b1, 12'hFFF, 32'hFFFFFFFF, 16'hFFFF);
		push_item(KIND_FIND, 1'b1, 12'h000, 32'hFFFFFFFE, 16'h0000);
		push_item(KIND_FIND, 1'b0, 12'h008, 32'h00000000, 16'h0000);
		push_item(KIND_APPEND, 1'b0, 12'h008, 32'hA5A5A5A5, 16'h8000);
		push_item(KIND_FIND, 1'b0, 12'h008, 32'hA5A5A5A5, 16'h0000);
		push_item(KIND_FIND, 1'b0, 12'h000, 32'hFFFFFFFF, 16'h0000);
		push_item(KIND_SPARE, 1'b1, 12'hABC, 32'h87654321, 16'h4321);
		push_item(KIND_APPEND, 1'b1, 12'h000, 32'h5555AAAA, 16'hAAAA);
		push_item(KIND_APPEND, 1'b1, 12'h000, 32'h5555AAAA, 16'h5555);
		push_item(KIND_FIND, 1'b0, 12'h001, 32'h00000000, 16'h0000);
		push_item(KIND_CLEAR, 1'b0, 12'hFFF, 32'hFFFFFFFF, 16'hFFFF);
		push_item(KIND_FIND, 1'b1, 12'h000, 32'h00000000, 16'h0000);
		push_item(KIND_APPEND, 1'b0, 12'h000, 32'h11111111, 16'h0F0F);
		push_item(KIND_APPEND, 1'b1, 12'h000, 32'h11111111, 16'hF0F0);
		push_item(KIND_CLEAR, 1'b1, 12'h000, 32'h00000000, 16'h0000);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill the pool from the root until it runs out
		k = 0;
		while (nodes_alloc < NODE_COUNT) begin
			while (pending_q.size() >= 2)
				@(negedge clk);
			if (k % 8 == 7)
				push_item(KIND_FIND, 1'b1, NODE_W'($urandom), some_known_cp(),
					TAG_W'($urandom));
			else
				push_item(KIND_APPEND, 1'b1, NODE_W'($urandom), $urandom,
					TAG_W'($urandom));
			k++;
		end
		for (k = 0; k < 8; k++) begin
			push_item(KIND_APPEND, 1'b1, NODE_W'($urandom), $urandom, TAG_W'($urandom));
			push_item(KIND_FIND, k[0], NODE_W'($urandom), some_known_cp(),
				TAG_W'($urandom));
		end
		push_item(KIND_APPEND, 1'b0, 12'hFFF, $urandom, 16'hFFFF);
		push_item(KIND_FIND, 1'b0, 12'hFFF, 32'h00000000, 16'h0000);
		push_item(KIND_CLEAR, 1'b1, NODE_W'($urandom), $urandom, TAG_W'($urandom));

		while (n_total < RUN_ITEMS) begin
			while (pending_q.size() >= 2)
				@(negedge clk);
			push_random();
		end

		while (n_in < n_total || result_q.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/ntl_pkg.sv
rtl/core/ntl_walker.sv
rtl/core/nibble_trie_lookup_insert.sv
tb/tb_nibble_trie_lookup_insert.sv
